/* hdl/rmp_pkg.sv */
// Shared constants and types for the ROI mean and peak statistics block.
package rmp_pkg;

    // Default coordinate width (columns, rows, window fields)
    localparam int COORD_BITS_DEF = 12;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_ORIGIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_SIZE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_ORIGIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_SIZE        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION_LEVEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BRIGHTNESS   = 3'd6;

    // Register reset values
    localparam int FRAME_WIDTH_RST = 640;
    localparam logic [7:0] SATURATION_LEVEL_RST = 8'd250;

    // Data widths
    localparam int PIX_W  = 8;
    localparam int SUM_W  = 32;
    localparam int MEAN_W = 16;
    // sum * 256 + area / 2 fits in one bit more than sum * 256
    localparam int NUM_W  = SUM_W + 8 + 1;

    // Depth of the queue between front and back
    localparam int FIFO_DEPTH = 2;

    // Per-frame totals handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] dark_sum;
        logic [SUM_W-1:0] signal_sum;
        logic [PIX_W-1:0] signal_max;
    } frame_sums_t;

endpackage

/* hdl/rmp_pix_if.sv */
// Pixel input channel: valid/ready handshake with pixel and frame markers.
interface rmp_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       frame_start;
    logic       frame_end;

    modport source (output valid, output pixel, output frame_start, output frame_end,
                    input ready);
    modport sink (input valid, input pixel, input frame_start, input frame_end,
                  output ready);
endinterface

/* hdl/rmp_res_if.sv */
// Result output channel: valid/ready handshake with per-frame statistics.
interface rmp_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] dark_level;
    logic [15:0] brightness;
    logic [7:0]  signal_peak;
    logic        saturated;
    logic        frame_valid;

    modport source (output valid, output dark_level, output brightness,
                    output signal_peak, output saturated, output frame_valid,
                    input ready);
    modport sink (input valid, input dark_level, input brightness,
                  input signal_peak, input saturated, input frame_valid,
                  output ready);
endinterface

/* hdl/rmp_fifo.sv */
// Short queue of frame totals between the pixel front end and the divider back end.
module rmp_fifo
    import rmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  frame_sums_t push_data,
    output logic        full,
    input  logic        pop,
    output frame_sums_t pop_data,
    output logic        empty
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    frame_sums_t         entry_reg [FIFO_DEPTH];
    logic [AW-1:0]       wr_ptr_reg;
    logic [AW-1:0]       rd_ptr_reg;
    logic [CW-1:0]       count_reg;

    assign full     = (count_reg == CW'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/rmp_front.sv */
// Front end: raster counters, window hit tests, sum and peak accumulation per pixel.
module rmp_front
    import rmp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    rmp_pix_if.sink                 pix,
    input  logic [COORD_BITS-1:0]   frame_width,
    input  logic [2*COORD_BITS-1:0] signal_origin,
    input  logic [2*COORD_BITS-1:0] signal_size,
    input  logic [2*COORD_BITS-1:0] dark_origin,
    input  logic [2*COORD_BITS-1:0] dark_size,
    output logic                    push,
    output frame_sums_t             push_data,
    input  logic                    fifo_full
);

    localparam int C = COORD_BITS;

    logic [C-1:0]     col_reg;
    logic [C-1:0]     row_reg;
    logic [SUM_W-1:0] sig_sum_reg;
    logic [SUM_W-1:0] dark_sum_reg;
    logic [PIX_W-1:0] sig_max_reg;

    logic [C-1:0]     col_cur;
    logic [C-1:0]     row_cur;
    logic [SUM_W-1:0] sig_sum_cur;
    logic [SUM_W-1:0] dark_sum_cur;
    logic [PIX_W-1:0] sig_max_cur;
    logic [C-1:0]     col_next;
    logic [C-1:0]     row_next;
    logic [SUM_W-1:0] sig_sum_next;
    logic [SUM_W-1:0] dark_sum_next;
    logic [PIX_W-1:0] sig_max_next;
    logic             sig_hit;
    logic             dark_hit;
    logic             accept;

    // Window test; edges are computed one bit wider so they never wrap
    function automatic logic win_hit(input logic [2*C-1:0] origin,
                                     input logic [2*C-1:0] size,
                                     input logic [C-1:0]   col,
                                     input logic [C-1:0]   row);
        logic [C:0] x_end;
        logic [C:0] y_end;
        x_end = {1'b0, origin[C-1:0]} + {1'b0, size[C-1:0]};
        y_end = {1'b0, origin[2*C-1:C]} + {1'b0, size[2*C-1:C]};
        return (col >= origin[C-1:0]) && ({1'b0, col} < x_end) &&
               (row >= origin[2*C-1:C]) && ({1'b0, row} < y_end);
    endfunction

    // Saturating accumulate
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W + 1)'(b);
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    assign pix.ready = !fifo_full;
    assign accept    = pix.valid && pix.ready;

    // Frame start clears the running state before this pixel counts
    always_comb
    begin
        col_cur      = pix.frame_start ? '0 : col_reg;
        row_cur      = pix.frame_start ? '0 : row_reg;
        sig_sum_cur  = pix.frame_start ? '0 : sig_sum_reg;
        dark_sum_cur = pix.frame_start ? '0 : dark_sum_reg;
        sig_max_cur  = pix.frame_start ? '0 : sig_max_reg;

        sig_hit  = win_hit(signal_origin, signal_size, col_cur, row_cur);
        dark_hit = win_hit(dark_origin, dark_size, col_cur, row_cur);

        sig_sum_next  = sig_hit ? sat_add(sig_sum_cur, pix.pixel) : sig_sum_cur;
        dark_sum_next = dark_hit ? sat_add(dark_sum_cur, pix.pixel) : dark_sum_cur;
        sig_max_next  = (sig_hit && (pix.pixel > sig_max_cur)) ? pix.pixel : sig_max_cur;

        // Column wraps at the frame width or at the counter's top value
        if ((col_cur == '1) || (({1'b0, col_cur} + 1'b1) >= {1'b0, frame_width}))
        begin
            col_next = '0;
            row_next = row_cur + 1'b1;
        end
        else
        begin
            col_next = col_cur + 1'b1;
            row_next = row_cur;
        end
    end

    // Last pixel hands the totals to the queue
    assign push                 = accept && pix.frame_end;
    assign push_data.dark_sum   = dark_sum_next;
    assign push_data.signal_sum = sig_sum_next;
    assign push_data.signal_max = sig_max_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            sig_sum_reg  <= '0;
            dark_sum_reg <= '0;
            sig_max_reg  <= '0;
        end
        else if (accept)
        begin
            if (pix.frame_end)
            begin
                col_reg      <= '0;
                row_reg      <= '0;
                sig_sum_reg  <= '0;
                dark_sum_reg <= '0;
                sig_max_reg  <= '0;
            end
            else
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                sig_sum_reg  <= sig_sum_next;
                dark_sum_reg <= dark_sum_next;
                sig_max_reg  <= sig_max_next;
            end
        end
    end

endmodule

/* hdl/rmp_back.sv */
// Back end: window areas, bit-serial 8.8 mean division and result formatting.
module rmp_back
    import rmp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fifo_empty,
    input  frame_sums_t             fifo_data,
    output logic                    fifo_pop,
    input  logic [2*COORD_BITS-1:0] signal_size,
    input  logic [2*COORD_BITS-1:0] dark_size,
    input  logic [7:0]              saturation_level,
    input  logic [15:0]             min_brightness,
    rmp_res_if.source               res
);

    localparam int C      = COORD_BITS;
    localparam int AREA_W = 2 * C;
    localparam int REM_W  = 2 * C + 1;
    localparam int CNT_W  = $clog2(MEAN_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AREA = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic              sel_reg, sel_next;          // 0: dark window, 1: signal window
    frame_sums_t       sums_reg, sums_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [MEAN_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MEAN_W-1:0] dark_mean_reg, dark_mean_next;
    logic [MEAN_W-1:0] sig_mean_reg, sig_mean_next;
    logic              out_valid_reg, out_valid_next;
    logic [MEAN_W-1:0] dark_level_reg, dark_level_next;
    logic [MEAN_W-1:0] brightness_reg, brightness_next;
    logic [PIX_W-1:0]  peak_reg, peak_next;
    logic              saturated_reg, saturated_next;
    logic              frame_valid_reg, frame_valid_next;

    logic [AREA_W-1:0] size_cur;
    logic [SUM_W-1:0]  sum_cur;
    logic [NUM_W-1:0]  num;
    logic [REM_W-1:0]  rem_sh;
    logic              rem_ge;
    logic              mean_wr;
    logic [MEAN_W-1:0] mean_val;
    logic [MEAN_W-1:0] bright;
    logic              sat;

    // Operands of the window being worked on
    always_comb
    begin
        size_cur = sel_reg ? signal_size : dark_size;
        sum_cur  = sel_reg ? sums_reg.signal_sum : sums_reg.dark_sum;
        num      = {1'b0, sum_cur, 8'd0} + NUM_W'(area_reg >> 1);
        rem_sh   = {rem_reg[REM_W-2:0], quo_reg[MEAN_W-1]};
        rem_ge   = rem_sh >= REM_W'(area_reg);
        bright   = (sig_mean_reg > dark_mean_reg) ? sig_mean_reg - dark_mean_reg : '0;
        sat      = sums_reg.signal_max >= saturation_level;
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        sel_next         = sel_reg;
        sums_next        = sums_reg;
        area_next        = area_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        dark_mean_next   = dark_mean_reg;
        sig_mean_next    = sig_mean_reg;
        out_valid_next   = out_valid_reg && !res.ready;
        dark_level_next  = dark_level_reg;
        brightness_next  = brightness_reg;
        peak_next        = peak_reg;
        saturated_next   = saturated_reg;
        frame_valid_next = frame_valid_reg;
        fifo_pop         = 1'b0;
        mean_wr          = 1'b0;
        mean_val         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!fifo_empty)
                begin
                    fifo_pop   = 1'b1;
                    sums_next  = fifo_data;
                    sel_next   = 1'b0;
                    state_next = S_AREA;
                end
            end
            S_AREA:
            begin
                area_next  = AREA_W'(size_cur[C-1:0]) * AREA_W'(size_cur[AREA_W-1:C]);
                state_next = S_PREP;
            end
            S_PREP:
            begin
                if (area_reg == '0)
                begin
                    mean_wr  = 1'b1;
                    mean_val = '0;
                end
                else if (NUM_W'(num[NUM_W-1:MEAN_W]) >= NUM_W'(area_reg))
                begin
                    // Quotient would not fit in 16 bits
                    mean_wr  = 1'b1;
                    mean_val = '1;
                end
                else
                begin
                    rem_next   = REM_W'(num[NUM_W-1:MEAN_W]);
                    quo_next   = num[MEAN_W-1:0];
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = rem_ge ? rem_sh - REM_W'(area_reg) : rem_sh;
                quo_next = {quo_reg[MEAN_W-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MEAN_W - 1))
                begin
                    mean_wr  = 1'b1;
                    mean_val = {quo_reg[MEAN_W-2:0], rem_ge};
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next   = 1'b1;
                    dark_level_next  = dark_mean_reg;
                    brightness_next  = bright;
                    peak_next        = sums_reg.signal_max;
                    saturated_next   = sat;
                    frame_valid_next = (bright >= min_brightness) && !sat;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished mean moves on to the signal window or to the result
        if (mean_wr)
        begin
            if (sel_reg)
            begin
                sig_mean_next = mean_val;
                state_next    = S_FIN;
            end
            else
            begin
                dark_mean_next = mean_val;
                sel_next       = 1'b1;
                state_next     = S_AREA;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        sel_reg         <= sel_next;
        sums_reg        <= sums_next;
        area_reg        <= area_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        cnt_reg         <= cnt_next;
        dark_mean_reg   <= dark_mean_next;
        sig_mean_reg    <= sig_mean_next;
        dark_level_reg  <= dark_level_next;
        brightness_reg  <= brightness_next;
        peak_reg        <= peak_next;
        saturated_reg   <= saturated_next;
        frame_valid_reg <= frame_valid_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.dark_level  = dark_level_reg;
    assign res.brightness  = brightness_reg;
    assign res.signal_peak = peak_reg;
    assign res.saturated   = saturated_reg;
    assign res.frame_valid = frame_valid_reg;

    // Partial remainder stays below the divisor throughout the division
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < REM_W'(area_reg)))
        else $error("divider remainder not below area");

    // A new result is only presented from the final state
    a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result loaded outside final state");

    // Queue is only read when it holds an entry
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> (!fifo_empty && (state_reg == S_IDLE)))
        else $error("queue popped while empty or busy");

endmodule

/* hdl/roi_mean_peak_frame_stats.sv */
// After a frame's last pixel transfer, the back end takes each window through
//   area, setup and up to 16 one-bit divider steps, then loads the result.
// Throughput: one pixel per cycle; the front end stalls only while the two-entry
//   queue holds two frames whose divisions are still pending.
// Reset (rst_n, async, active low): registers take their default values,
//   counters and sums clear, the queue and the output register empty.
module roi_mean_peak_frame_stats
    import rmp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    rmp_pix_if.sink                 pix,
    rmp_res_if.source               res,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [2*COORD_BITS-1:0] cfg_data
);

    localparam int C = COORD_BITS;

    logic [C-1:0]   frame_width_reg;
    logic [2*C-1:0] signal_origin_reg;
    logic [2*C-1:0] signal_size_reg;
    logic [2*C-1:0] dark_origin_reg;
    logic [2*C-1:0] dark_size_reg;
    logic [7:0]     saturation_level_reg;
    logic [15:0]    min_brightness_reg;

    logic           fifo_push;
    frame_sums_t    fifo_wdata;
    logic           fifo_full;
    logic           fifo_pop;
    frame_sums_t    fifo_rdata;
    logic           fifo_empty;

    // Configuration registers; unused indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg      <= C'(FRAME_WIDTH_RST);
            signal_origin_reg    <= '0;
            signal_size_reg      <= '0;
            dark_origin_reg      <= '0;
            dark_size_reg        <= '0;
            saturation_level_reg <= SATURATION_LEVEL_RST;
            min_brightness_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:      frame_width_reg      <= cfg_data[C-1:0];
                REG_SIGNAL_ORIGIN:    signal_origin_reg    <= cfg_data;
                REG_SIGNAL_SIZE:      signal_size_reg      <= cfg_data;
                REG_DARK_ORIGIN:      dark_origin_reg      <= cfg_data;
                REG_DARK_SIZE:        dark_size_reg        <= cfg_data;
                REG_SATURATION_LEVEL: saturation_level_reg <= cfg_data[7:0];
                REG_MIN_BRIGHTNESS:   min_brightness_reg   <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Pixel front end
    rmp_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix           (pix),
        .frame_width   (frame_width_reg),
        .signal_origin (signal_origin_reg),
        .signal_size   (signal_size_reg),
        .dark_origin   (dark_origin_reg),
        .dark_size     (dark_size_reg),
        .push          (fifo_push),
        .push_data     (fifo_wdata),
        .fifo_full     (fifo_full)
    );

    // Frame totals queue
    rmp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (fifo_wdata),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_data  (fifo_rdata),
        .empty     (fifo_empty)
    );

    // Division and result back end
    rmp_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .fifo_empty       (fifo_empty),
        .fifo_data        (fifo_rdata),
        .fifo_pop         (fifo_pop),
        .signal_size      (signal_size_reg),
        .dark_size        (dark_size_reg),
        .saturation_level (saturation_level_reg),
        .min_brightness   (min_brightness_reg),
        .res              (res)
    );

endmodule
